// ===== hw/rtl/mbsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsp_pkg
// Shared types, codes and decode helpers for the MIDI byte stream parser.
// ----------------------------------------------------------------------------
package mbsp_pkg;

  // configuration port
  localparam int          CFG_ADDR_W       = 3;
  localparam int          CFG_DATA_W       = 32;
  localparam int          LIMIT_W          = 7;
  localparam logic        REG_SYSEX_LIMIT  = 1'b0;   // word index, paddr[2]
  localparam logic [6:0]  SYSEX_LIMIT_RST  = 7'd3;
  localparam logic [6:0]  SYSEX_LIMIT_MIN  = 7'd3;

  // special bytes
  localparam logic [7:0]  BYTE_SYSEX_START = 8'hF0;
  localparam logic [7:0]  BYTE_SYSEX_END   = 8'hF7;

  // msg_kind codes
  localparam logic        KIND_SHORT       = 1'b0;
  localparam logic        KIND_SYSEX       = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_e;

  // one short message as produced by the assembler
  typedef struct packed {
    logic       emit;
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
    logic [1:0] len;
  } short_res_t;

  // message length for a status byte, 0 where the status is undefined
  function automatic logic [1:0] needed_len(input logic [7:0] status);
    logic [1:0] len;
    len = 2'd0;
    unique case (status[7:4]) inside
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 2'd3;
      4'hC, 4'hD:                   len = 2'd2;
      4'hF: begin
        unique case (status[3:0]) inside
          4'h6, 4'h8, 4'hA, 4'hB, 4'hC, 4'hE, 4'hF: len = 2'd1;
          4'h1, 4'h3:                               len = 2'd2;
          4'h2:                                     len = 2'd3;
          default:                                  len = 2'd0;
        endcase
      end
      default:                      len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/mbsp_sysex_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsp_sysex_mem
// System-exclusive byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mbsp_sysex_mem #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mbsp_short_asm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsp_short_asm
// Collects channel, system common and real-time messages byte by byte.
// ----------------------------------------------------------------------------
module mbsp_short_asm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output mbsp_pkg::short_res_t res_o
);

  import mbsp_pkg::*;

  logic       in_msg_q, in_msg_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] need_q, need_d;
  logic [7:0] status_q, status_d;
  logic [6:0] data1_q, data1_d;
  logic [1:0] cnt_inc;

  assign cnt_inc = cnt_q + 2'd1;

  always_comb begin
    in_msg_d = in_msg_q;
    cnt_d    = cnt_q;
    need_d   = need_q;
    status_d = status_q;
    data1_d  = data1_q;
    res_o    = '0;
    if (step_i) begin
      if (byte_i[7]) begin
        if (byte_i == BYTE_SYSEX_START) begin
          in_msg_d = 1'b0;
        end else begin
          in_msg_d     = 1'b1;
          status_d     = byte_i;
          cnt_d        = 2'd1;
          need_d       = needed_len(byte_i);
          res_o.emit   = (needed_len(byte_i) == 2'd1);
          res_o.status = byte_i;
          res_o.len    = 2'd1;
        end
      end else if (in_msg_q && cnt_q != 2'd3) begin
        cnt_d = cnt_inc;
        if (cnt_q == 2'd1) begin
          data1_d = byte_i[6:0];
        end
        res_o.emit   = (need_q != 2'd0) && (cnt_inc == need_q);
        res_o.status = status_q;
        res_o.data1  = (cnt_q == 2'd1) ? byte_i[6:0] : data1_q;
        res_o.data2  = (cnt_q == 2'd2) ? byte_i[6:0] : 7'd0;
        res_o.len    = need_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
      cnt_q    <= 2'd0;
      need_q   <= 2'd0;
    end else begin
      in_msg_q <= in_msg_d;
      cnt_q    <= cnt_d;
      need_q   <= need_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    data1_q  <= data1_d;
  end

endmodule

// ===== hw/rtl/midi_byte_stream_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_byte_stream_parser
// Turns a stream of received MIDI bytes into complete messages and
// system-exclusive byte runs.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel: one MIDI byte per word (rx_valid_i / rx_stall_o). A byte is
//   taken into a one-word input buffer, so a new byte can be accepted while a
//   result still waits at the output.
//   out channel: one result per word (out_valid_o / out_stall_i), held in an
//   output register until taken.
//   Each byte is registered in the buffer and then parsed once the output
//   register is free; the buffer takes no new byte until then. A short message
//   is registered in the output register when its last byte is parsed.
//   On F7 the stored system-exclusive bytes are replayed from the byte store,
//   each through a read state and a load state (the store's read port is
//   registered); no byte is parsed until the run is done.
//   A stall on the output simply holds the result; parsing waits behind it.
//   Reset clears all control state and sets sysex_limit to 3; no clearing
//   pass is needed since only bytes written in the current run are read.
//   sysex_limit lives at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser #(
  parameter int SYSEX_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // received bytes
  input  logic                              rx_valid_i,
  output logic                              rx_stall_o,
  input  logic [7:0]                        rx_byte_i,
  // results
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              msg_kind_o,
  output logic [7:0]                        status_or_data_o,
  output logic [6:0]                        first_data_o,
  output logic [6:0]                        second_data_o,
  output logic [1:0]                        msg_length_o,
  output logic                              last_o,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mbsp_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [mbsp_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [mbsp_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  import mbsp_pkg::*;

  localparam int              FillW     = $clog2(SYSEX_DEPTH + 1);
  localparam int              AddrW     = $clog2(SYSEX_DEPTH);
  localparam logic [LIMIT_W-1:0] DepthLim = LIMIT_W'(SYSEX_DEPTH);

  // configuration register
  logic [LIMIT_W-1:0] limit_q;
  logic [LIMIT_W-1:0] lim_eff;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SYSEX_LIMIT);
  assign prdata = (paddr[2] == REG_SYSEX_LIMIT) ?
                  CFG_DATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= SYSEX_LIMIT_RST;
    end else if (cfg_wr) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    if (limit_q < SYSEX_LIMIT_MIN) begin
      lim_eff = SYSEX_LIMIT_MIN;
    end else if (limit_q > DepthLim) begin
      lim_eff = DepthLim;
    end else begin
      lim_eff = limit_q;
    end
  end

  // control state
  state_e           state_q, state_d;
  logic             in_full_q, in_full_d;
  logic [7:0]       in_byte_q, in_byte_d;
  logic             in_sysex_q, in_sysex_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] run_len_q, run_len_d;
  logic [FillW-1:0] rd_idx_q, rd_idx_d;
  logic [FillW-1:0] fill_inc, rd_idx_inc;

  // output register
  logic             out_valid_q, out_valid_d;
  logic             kind_q, kind_d;
  logic [7:0]       sod_q, sod_d;
  logic [6:0]       d1_q, d1_d;
  logic [6:0]       d2_q, d2_d;
  logic [1:0]       len_q, len_d;
  logic             last_q, last_d;

  logic             out_free, rx_take, proc, short_step;
  logic             mem_we, mem_re;
  logic [7:0]       mem_rdata;
  short_res_t       short_res;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign rx_stall_o = in_full_q;
  assign rx_take    = rx_valid_i && !in_full_q;
  assign proc       = (state_q == ST_IDLE) && in_full_q && out_free;
  assign short_step = proc && !in_sysex_q;
  assign fill_inc   = fill_q + FillW'(1);
  assign rd_idx_inc = rd_idx_q + FillW'(1);

  mbsp_short_asm u_short (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (short_step),
    .byte_i (in_byte_q),
    .res_o  (short_res)
  );

  // store is written only while collecting and read only during replay
  mbsp_sysex_mem #(
    .Depth (SYSEX_DEPTH),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (fill_q[AddrW-1:0]),
    .wdata_i (in_byte_q),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    in_full_d   = in_full_q;
    in_byte_d   = in_byte_q;
    in_sysex_d  = in_sysex_q;
    fill_d      = fill_q;
    run_len_d   = run_len_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    sod_d       = sod_q;
    d1_d        = d1_q;
    d2_d        = d2_q;
    len_d       = len_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (proc) begin
          in_full_d = 1'b0;
          if (in_sysex_q) begin
            mem_we = 1'b1;
            if (in_byte_q == BYTE_SYSEX_END) begin
              run_len_d  = fill_inc;
              rd_idx_d   = '0;
              fill_d     = '0;
              in_sysex_d = 1'b0;
              state_d    = ST_READ;
            end else if (LIMIT_W'(fill_inc) >= lim_eff) begin
              // overflow: drop the run
              fill_d     = '0;
              in_sysex_d = 1'b0;
            end else begin
              fill_d = fill_inc;
            end
          end else begin
            if (in_byte_q == BYTE_SYSEX_START) begin
              in_sysex_d = 1'b1;
              fill_d     = '0;
            end
            if (short_res.emit) begin
              out_valid_d = 1'b1;
              kind_d      = KIND_SHORT;
              sod_d       = short_res.status;
              d1_d        = short_res.data1;
              d2_d        = short_res.data2;
              len_d       = short_res.len;
              last_d      = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_SYSEX;
          sod_d       = mem_rdata;
          d1_d        = 7'd0;
          d2_d        = 7'd0;
          len_d       = 2'd1;
          last_d      = (rd_idx_inc == run_len_q);
          rd_idx_d    = rd_idx_inc;
          state_d     = (rd_idx_inc == run_len_q) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (rx_take) begin
      in_full_d = 1'b1;
      in_byte_d = rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_full_q   <= 1'b0;
      in_sysex_q  <= 1'b0;
      fill_q      <= '0;
      run_len_q   <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_full_q   <= in_full_d;
      in_sysex_q  <= in_sysex_d;
      fill_q      <= fill_d;
      run_len_q   <= run_len_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    kind_q    <= kind_d;
    sod_q     <= sod_d;
    d1_q      <= d1_d;
    d2_q      <= d2_d;
    len_q     <= len_d;
    last_q    <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign msg_kind_o       = kind_q;
  assign status_or_data_o = sod_q;
  assign first_data_o     = d1_q;
  assign second_data_o    = d2_q;
  assign msg_length_o     = len_q;
  assign last_o           = last_q;

`ifndef SYNTH
  // the store never fills past its depth while collecting
  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_sysex_q |-> (fill_q < FillW'(SYSEX_DEPTH)))
    else $error("sysex fill count beyond store depth");

  // replay only runs outside collection
  a_replay_not_sysex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_sysex_q)
    else $error("replay while collecting sysex");

  // replay reads stay inside the stored run
  a_replay_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ || state_q == ST_LOAD) |-> (rd_idx_q < run_len_q))
    else $error("replay index past run length");

  // the store is never written and read in the same cycle
  a_mem_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("store written and read together");
`endif

endmodule

// ===== sim/tb_midi_byte_stream_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_byte_stream_parser
// Self-checking bench for the MIDI byte stream parser. A directed table walks
// the message types and corner cases, then random message streams run under
// several sysex limits. Every accepted byte goes through a local parser model
// and every result word is checked against the oldest expected word.
// ----------------------------------------------------------------------------
module tb_midi_byte_stream_parser;
  import mbsp_pkg::*;

  localparam int SYSEX_DEPTH   = 64;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_BYTES   = 50;
  localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR = {REG_SYSEX_LIMIT, 2'b00};

  typedef struct packed {
    logic       kind;
    logic [7:0] sod;
    logic [6:0] d1;
    logic [6:0] d2;
    logic [1:0] len;
    logic       last;
  } midi_res_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    midi_res_t  res;
  } dir_row_t;

  localparam midi_res_t NO_RES = '0;
  localparam int        N_DIR  = 28;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  rx_valid_i;
  logic                  rx_stall_o;
  logic [7:0]            rx_byte_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  msg_kind_o;
  logic [7:0]            status_or_data_o;
  logic [6:0]            first_data_o;
  logic [6:0]            second_data_o;
  logic [1:0]            msg_length_o;
  logic                  last_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // parser model state
  logic       parse_in_sysex;
  logic       parse_in_msg;
  logic [6:0] parse_fill;
  logic [7:0] parse_short [3];
  logic [7:0] sysex_buf [SYSEX_DEPTH];
  logic [6:0] sysex_limit_reg;

  midi_res_t  expected_msgs [$];
  midi_res_t  byte_msgs [$];
  dir_row_t   typed_q [$];
  int         fail_count;
  int         bytes_sent;
  bit         rx_calm;
  bit         out_calm;
  bit         hold_req;

  // directed stream; typed rows carry the result to expect, the rest use the model
  dir_row_t dir_rows [N_DIR] = '{
    {8'h00, 1'b0, NO_RES},                                           // data while idle
    {8'hF8, 1'b1, KIND_SHORT, 8'hF8, 7'h00, 7'h00, 2'd1, 1'b1},
    {8'h90, 1'b0, NO_RES},
    {8'h00, 1'b0, NO_RES},
    {8'h00, 1'b1, KIND_SHORT, 8'h90, 7'h00, 7'h00, 2'd3, 1'b1},
    {8'h7F, 1'b0, NO_RES},                                           // extra data
    {8'h8F, 1'b0, NO_RES},
    {8'h7F, 1'b0, NO_RES},
    {8'h7F, 1'b1, KIND_SHORT, 8'h8F, 7'h7F, 7'h7F, 2'd3, 1'b1},
    {8'hC5, 1'b0, NO_RES},
    {8'h12, 1'b1, KIND_SHORT, 8'hC5, 7'h12, 7'h00, 2'd2, 1'b1},
    {8'h34, 1'b0, NO_RES},                                           // no running status
    {8'hF4, 1'b0, NO_RES},                                           // undefined status
    {8'h55, 1'b0, NO_RES},
    {8'hE0, 1'b0, NO_RES},
    {8'h01, 1'b0, NO_RES},
    {8'hF2, 1'b0, NO_RES},                                           // abandons pitch bend
    {8'h7F, 1'b0, NO_RES},
    {8'h00, 1'b1, KIND_SHORT, 8'hF2, 7'h7F, 7'h00, 2'd3, 1'b1},
    {8'hF0, 1'b0, NO_RES},
    {8'hFE, 1'b0, NO_RES},                                           // real-time inside sysex
    {8'h44, 1'b0, NO_RES},
    {8'hF7, 1'b0, NO_RES},                                           // F7 replays the stored run
    {8'hF0, 1'b0, NO_RES},
    {8'h11, 1'b0, NO_RES},
    {8'h22, 1'b0, NO_RES},
    {8'h33, 1'b0, NO_RES},                                           // overflow, dropped
    {8'hFF, 1'b1, KIND_SHORT, 8'hFF, 7'h00, 7'h00, 2'd1, 1'b1}
  };

  midi_byte_stream_parser #(
    .SYSEX_DEPTH(SYSEX_DEPTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid_i),
    .rx_stall_o       (rx_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .msg_kind_o       (msg_kind_o),
    .status_or_data_o (status_or_data_o),
    .first_data_o     (first_data_o),
    .second_data_o    (second_data_o),
    .msg_length_o     (msg_length_o),
    .last_o           (last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned status_length(input logic [7:0] s);
    int unsigned n;
    n = 0;
    case (s[7:4])
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 3;
      4'hC, 4'hD:                   n = 2;
      4'hF: begin
        case (s[3:0])
          4'h2:                                     n = 3;
          4'h1, 4'h3:                               n = 2;
          4'h6, 4'h8, 4'hA, 4'hB, 4'hC, 4'hE, 4'hF: n = 1;
          default:                                  n = 0;
        endcase
      end
      default: n = 0;
    endcase
    return n;
  endfunction

  function automatic int unsigned active_limit();
    int unsigned l;
    l = sysex_limit_reg;
    if (l < SYSEX_LIMIT_MIN) l = SYSEX_LIMIT_MIN;
    if (l > SYSEX_DEPTH) l = SYSEX_DEPTH;
    return l;
  endfunction

  // advance the model by one byte, leaving its results in byte_msgs
  function automatic void parse_midi_byte(input logic [7:0] b);
    int unsigned lim;
    int unsigned n;
    int unsigned need;
    midi_res_t   r;
    byte_msgs.delete();
    lim = active_limit();
    if (parse_in_sysex) begin
      if (parse_fill < SYSEX_DEPTH) sysex_buf[parse_fill] = b;
      parse_fill = parse_fill + 7'd1;
      if (b == BYTE_SYSEX_END) begin
        n = (parse_fill > SYSEX_DEPTH) ? SYSEX_DEPTH : parse_fill;
        for (int k = 0; k < n; k++) begin
          r.kind = KIND_SYSEX;
          r.sod  = sysex_buf[k];
          r.d1   = '0;
          r.d2   = '0;
          r.len  = 2'd1;
          r.last = (k + 1 == n);
          byte_msgs.insert(byte_msgs.size(), r);
        end
        parse_in_sysex = 1'b0;
        parse_fill     = '0;
      end else if (parse_fill >= lim) begin
        parse_in_sysex = 1'b0;
        parse_fill     = '0;
      end
      return;
    end
    if (b[7]) begin
      parse_fill = '0;
      if (b == BYTE_SYSEX_START) begin
        parse_in_sysex = 1'b1;
        parse_in_msg   = 1'b0;
        return;
      end
      parse_in_msg = 1'b1;
    end
    if (!parse_in_msg || parse_fill >= 3) return;
    parse_short[parse_fill] = b;
    parse_fill = parse_fill + 7'd1;
    need = status_length(parse_short[0]);
    if (need == 0 || parse_fill != need) return;
    r.kind = KIND_SHORT;
    r.sod  = parse_short[0];
    r.d1   = (need >= 2) ? parse_short[1][6:0] : 7'd0;
    r.d2   = (need >= 3) ? parse_short[2][6:0] : 7'd0;
    r.len  = need[1:0];
    r.last = 1'b1;
    byte_msgs.insert(byte_msgs.size(), r);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 15);
    if (r == 0) return $urandom_range(10, 40);
    if (r < 6) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    midi_res_t want;
    dir_row_t  row;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_msgs.size() == 0) begin
          $error("result word with nothing expected: kind %0d, byte %h",
                 msg_kind_o, status_or_data_o);
          fail_count++;
        end else begin
          want = expected_msgs.pop_front();
          check_field("msg_kind", want.kind, msg_kind_o);
          check_field("status_or_data", want.sod, status_or_data_o);
          check_field("first_data", want.d1, first_data_o);
          check_field("second_data", want.d2, second_data_o);
          check_field("msg_length", want.len, msg_length_o);
          check_field("last", want.last, last_o);
        end
      end
      if (rx_valid_i && !rx_stall_o) begin
        parse_midi_byte(rx_byte_i);
        row = '0;
        if (typed_q.size() != 0) row = typed_q.pop_front();
        if (row.typed) expected_msgs.insert(expected_msgs.size(), row.res);
        else foreach (byte_msgs[i]) expected_msgs.insert(expected_msgs.size(), byte_msgs[i]);
      end
    end
  end

  // result side: random stall, calm stretches, and one long hold on request
  initial begin : sink
    int unsigned stall_left;
    stall_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (!out_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b0) + 1;
      end
    end
  end

  // called just after a rising edge; returns at the edge that took the word, or after the gap that follows it
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (rx_stall_o);
    bytes_sent++;
    gap = pick_gap(rx_calm);
    if (gap != 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_block();
    rx_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_msgs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_sysex_limit(input logic [6:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= CFG_DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sysex_limit_reg = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("sysex_limit readback", v, prdata[6:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random_sequence();
    int unsigned kind;
    int unsigned n;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
    if (kind < 50) begin
      if ($urandom_range(0, 3) == 0) begin
        do b = 8'hF0 | 8'($urandom_range(0, 15)); while (status_length(b) == 0);
      end else begin
        b = 8'($urandom_range(8'h80, 8'hEF));
      end
      n = status_length(b) - 1;
      case ($urandom_range(0, 9))
        0:       if (n > 0) n = $urandom_range(0, n - 1);  // cut short
        1:       n = n + $urandom_range(1, 3);             // trailing data
        default: ;
      endcase
      send_byte(b);
      repeat (n) send_byte(8'($urandom_range(0, 127)));
    end else if (kind < 72) begin
      send_byte(BYTE_SYSEX_START);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, active_limit() + 1)
                                      : $urandom_range(0, 5);
      repeat (n) begin
        b = ($urandom_range(0, 19) == 0) ? 8'h80 | 8'($urandom_range(0, 127))
                                         : 8'($urandom_range(0, 127));
        if (b == BYTE_SYSEX_END) b = BYTE_SYSEX_START;
        send_byte(b);
      end
      if ($urandom_range(0, 9) != 0) send_byte(BYTE_SYSEX_END);
    end else if (kind < 85) begin
      do b = 8'hF0 | 8'($urandom_range(1, 15)); while (status_length(b) != 0);
      send_byte(b);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 127)));
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    logic [6:0] lim;
    int         phase_start;
    rst_ni          <= 1'b0;
    rx_valid_i      <= 1'b0;
    rx_byte_i       <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    fail_count      = 0;
    bytes_sent      = 0;
    rx_calm         = 1'b0;
    out_calm        = 1'b0;
    hold_req        = 1'b0;
    parse_in_sysex  = 1'b0;
    parse_in_msg    = 1'b0;
    parse_fill      = '0;
    parse_short     = '{default: 8'h00};
    sysex_limit_reg = SYSEX_LIMIT_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      typed_q.insert(typed_q.size(), dir_rows[i]);
      send_byte(dir_rows[i].rx);
    end

    // limit lowered while a sysex is open: next stored word drops it
    drain_block();
    set_sysex_limit(7'd12);
    send_byte(BYTE_SYSEX_START);
    repeat (4) send_byte(8'($urandom_range(0, 127)));
    drain_block();
    set_sysex_limit(7'd4);
    send_byte(8'($urandom_range(0, 127)));
    send_byte(BYTE_SYSEX_END);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       lim = SYSEX_LIMIT_MIN;
        1:       lim = 7'(SYSEX_DEPTH);
        2:       lim = 7'($urandom_range(4, 63));
        default: lim = 7'd12;
      endcase
      drain_block();
      set_sysex_limit(lim);
      phase_start = bytes_sent;
      if (ph == 1) begin
        // full-depth run replayed under a long output hold, so the input backs up
        send_byte(BYTE_SYSEX_START);
        repeat (SYSEX_DEPTH - 1) send_byte(8'($urandom_range(0, 127)));
        hold_req = 1'b1;
        send_byte(BYTE_SYSEX_END);
      end
      while (bytes_sent - phase_start < PHASE_BYTES) send_random_sequence();
    end

    drain_block();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
